// ===== sv/ssrctag_pkg.sv =====
// ---------------------------------------------------------------------------
// SSRC tag tracker package
// Shared codes, record layout and the command and status bundles that pass
// between the controller and the datapath.
// ---------------------------------------------------------------------------
package ssrctag_pkg;

   localparam int DEF_TABLE_ENTRIES = 16;

   localparam int SSRC_W = 32;
   localparam int TIME_W = 32;
   localparam int SEQ_W  = 16;
   localparam int RETAG_W = 16;

   localparam logic [RETAG_W-1:0] RETAG_RESET = 16'd5;

   // configuration register indexes (word address bit 2)
   localparam logic REG_TAGGING_ENABLED = 1'b0;
   localparam logic REG_RETAG_AFTER     = 1'b1;

   typedef enum logic [1:0] {
      FUNC_SENT   = 2'd0,
      FUNC_REPORT = 2'd1,
      FUNC_CLEAR  = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef struct packed {
      logic [SSRC_W-1:0] ssrc;
      logic [TIME_W-1:0] last_sent;
      logic              acked;
      logic [SEQ_W-1:0]  seq_first;
      logic [SEQ_W-1:0]  seq_last;
   } entry_type;

   typedef struct packed {
      logic               tagging_enabled;
      logic [RETAG_W-1:0] retag_after;
   } cfg_type;

   typedef struct packed {
      logic table_full;
      logic entry_hit;
      logic ack_set;
      logic add_tags;
   } result_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic rsp_busy;
   } status_type;

endpackage

// ===== sv/ssrctag_csr.sv =====
// ---------------------------------------------------------------------------
// SSRC tag tracker configuration registers
// APB-style register file holding the tagging enable and retag time.
// ---------------------------------------------------------------------------
module ssrctag_csr
   import ssrctag_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   logic               enable_ff;
   logic [RETAG_W-1:0] retag_ff;
   logic               wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         retag_ff  <= RETAG_RESET;
      end else if (wr_en) begin
         case (csr_paddr[2])
            REG_TAGGING_ENABLED: enable_ff <= csr_pwdata[0];
            REG_RETAG_AFTER:     retag_ff  <= csr_pwdata[RETAG_W-1:0];
            default:             enable_ff <= enable_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_TAGGING_ENABLED: csr_prdata = {31'd0, enable_ff};
         REG_RETAG_AFTER:     csr_prdata = {{(32-RETAG_W){1'b0}}, retag_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   assign cfg.tagging_enabled = enable_ff;
   assign cfg.retag_after     = retag_ff;

endmodule

// ===== sv/ssrctag_ctrl.sv =====
// ---------------------------------------------------------------------------
// SSRC tag tracker controller
// Sequences accept, table scan and update for one item at a time.
// ---------------------------------------------------------------------------
module ssrctag_ctrl
   import ssrctag_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EXEC = 3'b100
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.load = 1'b0;
      cmd.exec = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            // hold until the result register can take the new result
            if (!status.rsp_busy) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ===== sv/ssrctag_dpath.sv =====
// ---------------------------------------------------------------------------
// SSRC tag tracker datapath
// Entry memory, valid bits, pipelined key scan, entry update and the
// result register.
// ---------------------------------------------------------------------------
module ssrctag_dpath
   import ssrctag_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
)(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  cmd_type      cmd,
   output status_type   status,
   input  logic [1:0]   req_tuser,
   input  logic [95:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output result_type   rsp_result
);

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

   entry_type mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;

   func_type          func_ff;
   logic [SSRC_W-1:0] key_ff;
   logic [SEQ_W-1:0]  seq_ff;
   logic [TIME_W-1:0] now_ff;

   logic [IW-1:0] scan_addr_ff;
   logic          issuing_ff;
   logic [IW-1:0] rd_idx_ff;
   logic          rd_vld_ff;
   entry_type     rd_rec_ff;
   logic          scan_done_ff;

   logic          found_ff;
   logic [IW-1:0] hit_idx_ff;
   entry_type     hit_rec_ff;
   logic          free_found_ff;
   logic [IW-1:0] free_idx_ff;

   logic          rsp_valid_ff;
   result_type    result_ff;

   logic          match;
   logic          slot_free;

   logic          wr_en;
   logic [IW-1:0] wr_idx;
   entry_type     wr_rec;
   logic          set_valid;
   logic          clear_all;
   result_type    result_in;

   logic [TIME_W-1:0] idle_ticks;
   logic              stale;
   logic              acked_n;
   logic [SEQ_W:0]    win_first;
   logic [SEQ_W:0]    win_last;
   logic [SEQ_W:0]    win_seq;
   logic              in_window;

   assign match     = valid_ff[rd_idx_ff] && (rd_rec_ff.ssrc == key_ff);
   assign slot_free = !valid_ff[rd_idx_ff];

   // input capture and scan pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff    <= 1'b0;
         rd_vld_ff     <= 1'b0;
         scan_done_ff  <= 1'b0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmd.load) begin
         issuing_ff    <= 1'b1;
         rd_vld_ff     <= 1'b0;
         scan_done_ff  <= 1'b0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         rd_vld_ff <= issuing_ff;
         if (issuing_ff && scan_addr_ff == LAST_IDX) issuing_ff <= 1'b0;
         if (rd_vld_ff) begin
            if (match && !found_ff)         found_ff      <= 1'b1;
            if (slot_free && !free_found_ff) free_found_ff <= 1'b1;
            if (rd_idx_ff == LAST_IDX)      scan_done_ff  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff      <= func_type'(req_tuser);
         key_ff       <= req_tdata[31:0];
         seq_ff       <= req_tdata[SEQ_W+31:32];
         now_ff       <= req_tdata[95:64];
         scan_addr_ff <= '0;
      end else if (issuing_ff && scan_addr_ff != LAST_IDX) begin
         scan_addr_ff <= scan_addr_ff + 1'b1;
      end
      rd_idx_ff <= scan_addr_ff;
      if (rd_vld_ff && match && !found_ff) begin
         hit_idx_ff <= rd_idx_ff;
         hit_rec_ff <= rd_rec_ff;
      end
      if (rd_vld_ff && slot_free && !free_found_ff) free_idx_ff <= rd_idx_ff;
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) mem[wr_idx] <= wr_rec;
      rd_rec_ff <= mem[scan_addr_ff];
   end

   // update of the selected entry
   assign idle_ticks = now_ff - hit_rec_ff.last_sent;
   assign stale      = idle_ticks > {{(TIME_W-RETAG_W){1'b0}}, cfg.retag_after};
   assign acked_n    = stale ? 1'b0 : hit_rec_ff.acked;

   assign win_first = {1'b0, hit_rec_ff.seq_first};
   assign win_last  = {(hit_rec_ff.seq_last < hit_rec_ff.seq_first), hit_rec_ff.seq_last};
   assign win_seq   = {(seq_ff < hit_rec_ff.seq_first), seq_ff};
   assign in_window = (win_seq >= win_first) && (win_seq <= win_last);

   always_comb begin
      wr_en     = 1'b0;
      wr_idx    = hit_idx_ff;
      wr_rec    = hit_rec_ff;
      set_valid = 1'b0;
      clear_all = 1'b0;
      result_in = '0;
      case (func_ff)
         FUNC_SENT: begin
            if (cfg.tagging_enabled) begin
               if (found_ff) begin
                  result_in.entry_hit = 1'b1;
                  result_in.add_tags  = !acked_n;
                  wr_en            = 1'b1;
                  wr_rec.last_sent = now_ff;
                  wr_rec.acked     = acked_n;
                  if (stale)    wr_rec.seq_first = seq_ff;
                  if (!acked_n) wr_rec.seq_last  = seq_ff;
               end else if (free_found_ff) begin
                  result_in.add_tags = 1'b1;
                  wr_en            = 1'b1;
                  set_valid        = 1'b1;
                  wr_idx           = free_idx_ff;
                  wr_rec.ssrc      = key_ff;
                  wr_rec.last_sent = now_ff;
                  wr_rec.acked     = 1'b0;
                  wr_rec.seq_first = seq_ff;
                  wr_rec.seq_last  = seq_ff;
               end else begin
                  result_in.add_tags   = 1'b1;
                  result_in.table_full = 1'b1;
               end
            end
         end
         FUNC_REPORT: begin
            if (cfg.tagging_enabled && found_ff) begin
               result_in.entry_hit = 1'b1;
               if (!hit_rec_ff.acked && in_window) begin
                  result_in.ack_set = 1'b1;
                  wr_en        = 1'b1;
                  wr_rec.acked = 1'b1;
               end
            end
         end
         FUNC_CLEAR: clear_all = 1'b1;
         default:    clear_all = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.exec) begin
         if (clear_all)      valid_ff         <= '0;
         else if (set_valid) valid_ff[wr_idx] <= 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.exec) result_ff <= result_in;
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_result       = result_ff;
   assign status.scan_done = scan_done_ff;
   assign status.rsp_busy  = rsp_valid_ff && !rsp_tready;

endmodule

// ===== sv/ssrc_tag_ack_tracker.sv =====
// ---------------------------------------------------------------------------
// SSRC tag acknowledgement tracker
// Per-stream table deciding whether sent RTP packets still need tags.
// ---------------------------------------------------------------------------
// Usage: one request transfer per sent packet, receiver report block or
// clear command (kind on req_tuser); each gives exactly one response
// transfer carrying four flags on rsp_tdata. The table is keyed by SSRC and
// looked up by a scan of the entry memory, one entry per cycle through its
// single read port; one item is worked on at a time and the next is
// accepted in the cycle after the update.
// A finished response sits in the output register; while the receiver
// stalls, the next request is still taken and scanned, and its update
// holds until the output register is free.
// Reset empties the table through its valid bits at once (no clearing
// pass), disables tagging and sets the retag time to 5 ticks. Write the
// configuration registers only while no item is in flight.
// ---------------------------------------------------------------------------
module ssrc_tag_ack_tracker
   import ssrctag_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
)(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] func
   input  logic [95:0] req_tdata,   // [31:0] ssrc, [47:32] seq_value, [95:64] now_time
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] add_tags, [1] ack_set, [2] entry_hit,
                                    // [3] table_full, [7:4] zero
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   result_type result;

   // register file: tagging enable at 0x0, retag time at 0x4
   ssrctag_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer: accept, wait for the scan, then commit the update once the response register is free
   ssrctag_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // table memory, scan and update logic, response register
   ssrctag_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (result)
   );

   // pack the flags, lowest field first
   assign rsp_tdata = {4'd0, result.table_full, result.entry_hit,
                       result.ack_set, result.add_tags};

endmodule
